>>> hw/rtl/bvma_pkg.sv
// ----------------------------------------------------------------------------
// bvma_pkg
// Shared types and constants for the binary volume moment accumulator:
// payload words, configuration register codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bvma_pkg;

	// Fixed field widths
	localparam int COORD_BITS     = 8;
	localparam int EXP_BITS       = 2;
	localparam int MEAN_BITS      = 16;
	localparam int COUNT_BITS     = 25;
	localparam int SUM_BITS       = 32;
	localparam int CENT_BITS      = 16;
	localparam int MOMENT_BITS    = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// Defaults for the top-level parameters
	localparam int FRAC_BITS_DEF    = 8;
	localparam int MAX_EXPONENT_DEF = 2;

	// Input word
	typedef struct packed {
		logic                  voxel_bit;
		logic [COORD_BITS-1:0] band_index;
		logic [COORD_BITS-1:0] row_index;
		logic [COORD_BITS-1:0] col_index;
		logic                  last_voxel;
	} voxel_t;

	// Result word
	typedef struct packed {
		logic        [COUNT_BITS-1:0]  voxel_count;
		logic        [CENT_BITS-1:0]   centroid_band_q8;
		logic        [CENT_BITS-1:0]   centroid_row_q8;
		logic        [CENT_BITS-1:0]   centroid_col_q8;
		logic signed [MOMENT_BITS-1:0] moment_q8;
		logic                          moment_overflow;
	} result_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_BAND_EXP  = 3'd0,
		CFG_ROW_EXP   = 3'd1,
		CFG_COL_EXP   = 3'd2,
		CFG_MEAN_BAND = 3'd3,
		CFG_MEAN_ROW  = 3'd4,
		CFG_MEAN_COL  = 3'd5
	} cfg_reg_t;

	// Axis being worked on
	typedef enum logic [1:0] {
		AXIS_BAND = 2'd0,
		AXIS_ROW  = 2'd1,
		AXIS_COL  = 2'd2
	} axis_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DEV      = 3'd1,
		ST_MUL_LO   = 3'd2,
		ST_MUL_HI   = 3'd3,
		ST_NORM     = 3'd4,
		ST_ADD      = 3'd5,
		ST_DIV_LOAD = 3'd6,
		ST_DIV_RUN  = 3'd7
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic  load_item;
		logic  dev_load;
		logic  mul_lo;
		logic  mul_hi;
		logic  norm;
		logic  add_moment;
		logic  div_load;
		logic  emit;
		axis_t axis;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic                last;
		logic [EXP_BITS-1:0] exp_cur;
		logic                div_done;
		logic                out_free;
	} status_t;

endpackage

>>> hw/rtl/binary_volume_moment_accumulator.sv
// ----------------------------------------------------------------------------
// binary_volume_moment_accumulator
// Central moments of a binary 3D image streamed one voxel per word.
//
// Usage:
//   in_*  : voxel words (bit, band/row/col, last mark), valid/ready.
//   out_* : one result word per image (count, Q centroids, moment, flag).
//   cfg_* : register writes (exponents, Q centers), always ready; write only
//           while the block is idle.
// Voxels: a background voxel is taken in idle and needs no more work. A
//   foreground voxel is then sequenced while no new voxel is taken: per axis
//   a deviation load and as many power steps as its clamped exponent on the
//   shared 32-bit multiplier (low half, high half, renormalize), then the
//   moment add. Image end: after the last voxel, the divider is loaded and
//   runs bit-serial centroid division; the result goes to the output register.
// Stall: the result sits in the output register while new voxels are taken;
//   a following image end waits until that register is free.
// Reset: configuration registers and accumulators clear to zero; no result is pending.
// ----------------------------------------------------------------------------
module binary_volume_moment_accumulator #(
	parameter int FRAC_BITS    = bvma_pkg::FRAC_BITS_DEF,
	parameter int MAX_EXPONENT = bvma_pkg::MAX_EXPONENT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bvma_pkg::voxel_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bvma_pkg::result_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bvma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bvma_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	bvma_pkg::cmd_t    cmd;
	bvma_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bvma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.item_fg   (in_data.voxel_bit),
		.item_last (in_data.last_voxel),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.status    (status)
	);

	bvma_datapath #(
		.FRAC_BITS    (FRAC_BITS),
		.MAX_EXPONENT (MAX_EXPONENT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> hw/rtl/bvma_divider.sv
// ----------------------------------------------------------------------------
// bvma_divider
// Three-lane restoring divider, one quotient bit per cycle. The lanes share
// one divisor (the foreground count) and one step counter.
// ----------------------------------------------------------------------------
module bvma_divider #(
	parameter int NUM_BITS = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [2:0][NUM_BITS-1:0]            dividend,
	input  logic [bvma_pkg::COUNT_BITS-1:0]     divisor,
	output logic [2:0][NUM_BITS-1:0]            quotient,
	output logic                                done
);

	localparam int CW    = bvma_pkg::COUNT_BITS;
	localparam int CNT_W = $clog2(NUM_BITS + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [CW-1:0]            div_q;
	logic [2:0][CW-1:0]       rem_q;
	logic [2:0][NUM_BITS-1:0] quo_q;
	logic [2:0][CW-1:0]       rem_n;
	logic [2:0][NUM_BITS-1:0] quo_n;

	// One restoring step per lane
	always_comb begin
		logic [CW:0] rem_sh;
		for (int i = 0; i < 3; i++) begin
			rem_sh = {rem_q[i], quo_q[i][NUM_BITS-1]};
			if (rem_sh >= {1'b0, div_q}) begin
				rem_n[i] = CW'(rem_sh - {1'b0, div_q});
				quo_n[i] = {quo_q[i][NUM_BITS-2:0], 1'b1};
			end else begin
				rem_n[i] = rem_sh[CW-1:0];
				quo_n[i] = {quo_q[i][NUM_BITS-2:0], 1'b0};
			end
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CNT_W'(NUM_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Remainder and quotient registers
	always_ff @(posedge clk) begin
		if (load) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule

>>> hw/rtl/bvma_datapath.sv
// ----------------------------------------------------------------------------
// bvma_datapath
// Configuration registers, accumulators, the power-step multiplier with
// Q renormalization and saturation, the moment adder, the centroid divider
// and the output register.
// ----------------------------------------------------------------------------
module bvma_datapath #(
	parameter int FRAC_BITS    = bvma_pkg::FRAC_BITS_DEF,
	parameter int MAX_EXPONENT = bvma_pkg::MAX_EXPONENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bvma_pkg::voxel_t                   in_data,
	input  logic                               cfg_valid,
	input  logic [bvma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [bvma_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output bvma_pkg::result_t                  out_data,
	input  bvma_pkg::cmd_t                     cmd,
	output bvma_pkg::status_t                  status
);

	localparam int CB       = bvma_pkg::COORD_BITS;
	localparam int EB       = bvma_pkg::EXP_BITS;
	localparam int MB       = bvma_pkg::MEAN_BITS;
	localparam int CNTB     = bvma_pkg::COUNT_BITS;
	localparam int SB       = bvma_pkg::SUM_BITS;
	localparam int XB       = bvma_pkg::MOMENT_BITS;
	localparam int MAG_BITS = (CB + FRAC_BITS > MB) ? CB + FRAC_BITS : MB;
	localparam int DW       = MAG_BITS + 1;
	localparam int PWM      = 32 + MAG_BITS;
	localparam int PW       = 64 + MAG_BITS;
	localparam int QW       = PW - FRAC_BITS;
	localparam int NB       = SB + FRAC_BITS;

	// Configuration
	logic [EB-1:0] band_exp_q, row_exp_q, col_exp_q;
	logic [MB-1:0] mean_band_q, mean_row_q, mean_col_q;

	// Current voxel
	logic [CB-1:0] band_q, row_q, col_q;
	logic          last_q;

	// Accumulators
	logic [CNTB-1:0]      count_q;
	logic [SB-1:0]        band_sum_q, row_sum_q, col_sum_q;
	logic signed [XB-1:0] moment_q;
	logic                 overflow_q;

	// Term and deviation in sign-magnitude form
	logic                term_neg_q;
	logic [63:0]         term_mag_q;
	logic                dev_neg_q;
	logic [MAG_BITS-1:0] dev_mag_q;
	logic [PWM-1:0]      prod_lo_q, prod_hi_q;

	// Output register
	logic                out_valid_q;
	bvma_pkg::result_t   out_q;

	// Divider hookup
	logic [2:0][NB-1:0]  div_num;
	logic [2:0][NB-1:0]  div_quo;
	logic                div_done;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_exp_q  <= '0;
			row_exp_q   <= '0;
			col_exp_q   <= '0;
			mean_band_q <= '0;
			mean_row_q  <= '0;
			mean_col_q  <= '0;
		end else if (cfg_valid) begin
			case (bvma_pkg::cfg_reg_t'(cfg_index))
				bvma_pkg::CFG_BAND_EXP:  band_exp_q  <= cfg_data[EB-1:0];
				bvma_pkg::CFG_ROW_EXP:   row_exp_q   <= cfg_data[EB-1:0];
				bvma_pkg::CFG_COL_EXP:   col_exp_q   <= cfg_data[EB-1:0];
				bvma_pkg::CFG_MEAN_BAND: mean_band_q <= cfg_data[MB-1:0];
				bvma_pkg::CFG_MEAN_ROW:  mean_row_q  <= cfg_data[MB-1:0];
				bvma_pkg::CFG_MEAN_COL:  mean_col_q  <= cfg_data[MB-1:0];
				default: ;
			endcase
		end
	end

	// Axis select: coordinate, center and exponent
	logic [CB-1:0] coord_sel;
	logic [MB-1:0] mean_sel;
	logic [EB-1:0] exp_sel;
	always_comb begin
		case (cmd.axis)
			bvma_pkg::AXIS_BAND: begin
				coord_sel = band_q;
				mean_sel  = mean_band_q;
				exp_sel   = band_exp_q;
			end
			bvma_pkg::AXIS_ROW: begin
				coord_sel = row_q;
				mean_sel  = mean_row_q;
				exp_sel   = row_exp_q;
			end
			default: begin
				coord_sel = col_q;
				mean_sel  = mean_col_q;
				exp_sel   = col_exp_q;
			end
		endcase
	end

	logic [EB-1:0] exp_clamped;
	assign exp_clamped = (int'(exp_sel) > MAX_EXPONENT) ? EB'(MAX_EXPONENT) : exp_sel;

	// Deviation (coord << F) - mean
	logic [DW-1:0] dev_diff;
	logic [DW-1:0] dev_abs;
	assign dev_diff = DW'({coord_sel, {FRAC_BITS{1'b0}}}) - DW'(mean_sel);
	assign dev_abs  = dev_diff[DW-1] ? DW'(0) - dev_diff : dev_diff;

	// Shared 32 x MAG multiplier over the two halves of the term
	logic [31:0]    mul_a;
	logic [PWM-1:0] mul_p;
	assign mul_a = cmd.mul_hi ? term_mag_q[63:32] : term_mag_q[31:0];
	assign mul_p = {{MAG_BITS{1'b0}}, mul_a} * {{32{1'b0}}, dev_mag_q};

	// Renormalize: drop F bits, saturate on magnitude
	logic [PW-1:0] prod_full;
	logic [QW-1:0] q_full;
	logic          q_neg;
	logic [63:0]   q_limit;
	logic          q_over;
	assign prod_full = {prod_hi_q, 32'b0} + PW'(prod_lo_q);
	assign q_full    = prod_full[PW-1:FRAC_BITS];
	assign q_neg     = term_neg_q ^ dev_neg_q;
	assign q_limit   = q_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
	assign q_over    = (|q_full[QW-1:64]) || (q_full[63:0] > q_limit);

	// Moment add with signed saturation
	logic [XB+1:0] term_val;
	logic [XB+1:0] msum;
	logic          msum_hi, msum_lo;
	assign term_val = term_neg_q ? (XB+2)'(0) - {2'b0, term_mag_q} : {2'b0, term_mag_q};
	assign msum     = {{2{moment_q[XB-1]}}, moment_q} + term_val;
	assign msum_hi  = !msum[XB+1] && (msum[XB:XB-1] != 2'b00);
	assign msum_lo  = msum[XB+1] && (msum[XB:XB-1] != 2'b11);

	// Saturating sums for the incoming voxel
	logic [SB:0] band_add, row_add, col_add;
	assign band_add = {1'b0, band_sum_q} + (SB+1)'(in_data.band_index);
	assign row_add  = {1'b0, row_sum_q} + (SB+1)'(in_data.row_index);
	assign col_add  = {1'b0, col_sum_q} + (SB+1)'(in_data.col_index);

	// Accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			band_sum_q <= '0;
			row_sum_q  <= '0;
			col_sum_q  <= '0;
			moment_q   <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.emit) begin
			count_q    <= '0;
			band_sum_q <= '0;
			row_sum_q  <= '0;
			col_sum_q  <= '0;
			moment_q   <= '0;
			overflow_q <= 1'b0;
		end else if (cmd.load_item) begin
			if (in_data.voxel_bit) begin
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				band_sum_q <= band_add[SB] ? '1 : band_add[SB-1:0];
				row_sum_q  <= row_add[SB]  ? '1 : row_add[SB-1:0];
				col_sum_q  <= col_add[SB]  ? '1 : col_add[SB-1:0];
			end
		end else if (cmd.norm) begin
			if (q_over) begin
				overflow_q <= 1'b1;
			end
		end else if (cmd.add_moment) begin
			if (msum_hi) begin
				moment_q   <= {1'b0, {(XB-1){1'b1}}};
				overflow_q <= 1'b1;
			end else if (msum_lo) begin
				moment_q   <= {1'b1, {(XB-1){1'b0}}};
				overflow_q <= 1'b1;
			end else begin
				moment_q   <= msum[XB-1:0];
			end
		end
	end

	// Voxel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.load_item) begin
			last_q <= in_data.last_voxel;
		end
	end

	// Coordinates, term, deviation and partial products
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			band_q     <= in_data.band_index;
			row_q      <= in_data.row_index;
			col_q      <= in_data.col_index;
			term_neg_q <= 1'b0;
			term_mag_q <= 64'd1 << FRAC_BITS;
		end
		if (cmd.dev_load) begin
			dev_neg_q <= dev_diff[DW-1];
			dev_mag_q <= dev_abs[MAG_BITS-1:0];
		end
		if (cmd.mul_lo) begin
			prod_lo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			prod_hi_q <= mul_p;
		end
		if (cmd.norm) begin
			term_neg_q <= q_neg;
			term_mag_q <= q_over ? q_limit : q_full[63:0];
		end
	end

	// Centroid divider
	assign div_num[0] = {band_sum_q, {FRAC_BITS{1'b0}}};
	assign div_num[1] = {row_sum_q, {FRAC_BITS{1'b0}}};
	assign div_num[2] = {col_sum_q, {FRAC_BITS{1'b0}}};

	bvma_divider #(
		.NUM_BITS (NB)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (div_num),
		.divisor  (count_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	// Centroid: zero when empty, clipped to 16 bits
	logic [2:0][bvma_pkg::CENT_BITS-1:0] cent;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (count_q == '0) begin
				cent[i] = '0;
			end else if (|div_quo[i][NB-1:bvma_pkg::CENT_BITS]) begin
				cent[i] = '1;
			end else begin
				cent[i] = div_quo[i][bvma_pkg::CENT_BITS-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.voxel_count      <= count_q;
			out_q.centroid_band_q8 <= cent[0];
			out_q.centroid_row_q8  <= cent[1];
			out_q.centroid_col_q8  <= cent[2];
			out_q.moment_q8        <= moment_q;
			out_q.moment_overflow  <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status to controller
	assign status.last     = last_q;
	assign status.exp_cur  = exp_clamped;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

>>> hw/rtl/bvma_ctrl.sv
// ----------------------------------------------------------------------------
// bvma_ctrl
// Sequencer for one voxel: per axis a deviation load and a number of power
// steps (low half, high half, renormalize), then the moment add; on the
// last voxel the centroid division and the result write.
// ----------------------------------------------------------------------------
module bvma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              item_fg,
	input  logic              item_last,
	output logic              in_ready,
	output bvma_pkg::cmd_t    cmd,
	input  bvma_pkg::status_t status
);

	bvma_pkg::state_t state_q, state_n;
	bvma_pkg::axis_t  axis_q, axis_next;
	logic [bvma_pkg::EXP_BITS-1:0] step_q;
	logic             step_last;
	logic             axis_adv;
	logic             emit_state;

	assign step_last = (step_q + 1'b1) >= status.exp_cur;

	always_comb begin
		case (axis_q)
			bvma_pkg::AXIS_BAND: axis_next = bvma_pkg::AXIS_ROW;
			default:             axis_next = bvma_pkg::AXIS_COL;
		endcase
	end

	// Emit waits in the divider-run state once the quotients are ready
	assign emit_state = (state_q == bvma_pkg::ST_DIV_RUN) && status.div_done;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			bvma_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (item_fg) begin
						state_n = bvma_pkg::ST_DEV;
					end else if (item_last) begin
						state_n = bvma_pkg::ST_DIV_LOAD;
					end
				end
			end
			bvma_pkg::ST_DEV: begin
				if (status.exp_cur != '0) begin
					state_n = bvma_pkg::ST_MUL_LO;
				end else if (axis_q == bvma_pkg::AXIS_COL) begin
					state_n = bvma_pkg::ST_ADD;
				end
			end
			bvma_pkg::ST_MUL_LO: state_n = bvma_pkg::ST_MUL_HI;
			bvma_pkg::ST_MUL_HI: state_n = bvma_pkg::ST_NORM;
			bvma_pkg::ST_NORM: begin
				if (!step_last) begin
					state_n = bvma_pkg::ST_MUL_LO;
				end else if (axis_q == bvma_pkg::AXIS_COL) begin
					state_n = bvma_pkg::ST_ADD;
				end else begin
					state_n = bvma_pkg::ST_DEV;
				end
			end
			bvma_pkg::ST_ADD: begin
				state_n = status.last ? bvma_pkg::ST_DIV_LOAD : bvma_pkg::ST_IDLE;
			end
			bvma_pkg::ST_DIV_LOAD: state_n = bvma_pkg::ST_DIV_RUN;
			bvma_pkg::ST_DIV_RUN: begin
				if (status.div_done && status.out_free) begin
					state_n = bvma_pkg::ST_IDLE;
				end
			end
			default: state_n = bvma_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.axis       = axis_q;
		axis_adv       = 1'b0;
		case (state_q)
			bvma_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			bvma_pkg::ST_DEV: begin
				cmd.dev_load = 1'b1;
				axis_adv     = (status.exp_cur == '0);
			end
			bvma_pkg::ST_MUL_LO: cmd.mul_lo = 1'b1;
			bvma_pkg::ST_MUL_HI: cmd.mul_hi = 1'b1;
			bvma_pkg::ST_NORM: begin
				cmd.norm = 1'b1;
				axis_adv = step_last;
			end
			bvma_pkg::ST_ADD:      cmd.add_moment = 1'b1;
			bvma_pkg::ST_DIV_LOAD: cmd.div_load   = 1'b1;
			bvma_pkg::ST_DIV_RUN:  cmd.emit       = emit_state && status.out_free;
			default: ;
		endcase
	end

	// State, axis and power-step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvma_pkg::ST_IDLE;
			axis_q  <= bvma_pkg::AXIS_BAND;
			step_q  <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.load_item) begin
				axis_q <= bvma_pkg::AXIS_BAND;
			end else if (axis_adv && axis_q != bvma_pkg::AXIS_COL) begin
				axis_q <= axis_next;
			end
			if (cmd.dev_load) begin
				step_q <= '0;
			end else if (cmd.norm) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Checks
	a_lo_then_hi: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_lo |=> cmd.mul_hi)
		else $error("high half did not follow low half");

	a_hi_then_norm: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_hi |=> cmd.norm)
		else $error("renormalize did not follow high half");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm |-> (step_q < status.exp_cur))
		else $error("power step beyond exponent");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (status.out_free && status.div_done))
		else $error("result written into a busy output register");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> !status.div_done)
		else $error("divider reported done right after load");

endmodule
